// ===== rtl/core/rog_pkg.sv =====
// ----------------------------------------------------------------------------
// rog_pkg
// Types, codes and region helpers shared by the occupancy grid modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rog_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_RECTS  = 255;
    localparam int MAX_RADIUS = 8;

    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int CELL_AW   = COL_BITS + ROW_BITS;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int ID_W      = 8;
    localparam int GEO_DEPTH = 1 << ID_W;
    localparam int RAD_W     = $clog2(MAX_RADIUS);
    localparam int CW        = 10;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [2:0] {
        FN_PLACE, FN_TELEPORT, FN_SLIDE, FN_REMOVE,
        FN_READ, FN_AREA, FN_RAY, FN_RING
    } t_func;

    typedef enum logic [1:0] {ST_OK, ST_BLOCKED, ST_NONE, ST_OOB} t_status;

    typedef enum logic [1:0] {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT} t_dir;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GEO, S_SCAN, S_SCAN_W, S_FILL, S_FETCH, S_FETCH_W, S_EMIT
    } t_state;

    // width and height stored minus one
    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [5:0] wm1;
        logic [5:0] hm1;
    } t_geo;

    // outer coordinate steps by one toward oe, inner runs is..ie-1
    typedef struct packed {
        t_coord os;
        t_coord oe;
        t_coord is;
        t_coord ie;
        logic   odn;
        logic   swap;
    } t_region;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [CELL_AW-1:0] addr;
        logic [ID_W-1:0]    wdata;
    } t_map_req;

    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_addr;
        logic            wr_en;
        logic [ID_W-1:0] wr_addr;
        t_geo            wr_geo;
        logic [ID_W-1:0] live_addr;
        logic            live_set;
        logic            live_clr;
    } t_tbl_req;

    function automatic t_region raster(input t_coord x1, input t_coord y1,
                                       input t_coord x2, input t_coord y2);
        t_region r;
        r.os   = y1;
        r.oe   = y2;
        r.is   = x1;
        r.ie   = x2;
        r.odn  = 1'b0;
        r.swap = 1'b0;
        return r;
    endfunction

    function automatic t_region ray_region(input t_coord gx, input t_coord gy,
                                           input t_coord gw, input t_coord gh,
                                           input t_coord cols, input t_coord rows,
                                           input t_dir dir);
        t_region r;
        unique case (dir)
            DIR_UP: begin
                r.os = gy - 1; r.oe = -1; r.odn = 1'b1; r.swap = 1'b0;
                r.is = gx; r.ie = gx + gw;
            end
            DIR_DOWN: begin
                r.os = gy + gh; r.oe = rows; r.odn = 1'b0; r.swap = 1'b0;
                r.is = gx; r.ie = gx + gw;
            end
            DIR_LEFT: begin
                r.os = gx - 1; r.oe = -1; r.odn = 1'b1; r.swap = 1'b1;
                r.is = gy; r.ie = gy + gh;
            end
            default: begin
                r.os = gx + gw; r.oe = cols; r.odn = 1'b0; r.swap = 1'b1;
                r.is = gy; r.ie = gy + gh;
            end
        endcase
        return r;
    endfunction

    // ring sides: left column, right column, top row, bottom row
    function automatic t_region ring_region(input t_coord gx, input t_coord gy,
                                            input t_coord gw, input t_coord gh,
                                            input t_coord rad, input logic [1:0] side);
        t_region r;
        t_coord  x1, x2, y1, y2;
        x1 = gx - rad;
        x2 = gx + gw + rad;
        y1 = gy - rad;
        y2 = gy + gh + rad;
        r.odn = 1'b0;
        unique case (side)
            2'd0: begin r.swap = 1'b1; r.os = x1;     r.is = y1; r.ie = y2; end
            2'd1: begin r.swap = 1'b1; r.os = x2 - 1; r.is = y1; r.ie = y2; end
            2'd2: begin r.swap = 1'b0; r.os = y1;     r.is = x1; r.ie = x2; end
            default: begin r.swap = 1'b0; r.os = y2 - 1; r.is = x1; r.ie = x2; end
        endcase
        r.oe = r.os + 1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rog_cell_map.sv =====
// ----------------------------------------------------------------------------
// rog_cell_map
// Cell owner memory, one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rog_cell_map (
    input  wire logic                   i_clk,
    input  wire rog_pkg::t_map_req      i_req,
    output logic [rog_pkg::ID_W-1:0]    o_rdata
);

    logic [rog_pkg::ID_W-1:0] mem [rog_pkg::CELLS];
    logic [rog_pkg::ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/rog_rect_table.sv =====
// ----------------------------------------------------------------------------
// rog_rect_table
// Rectangle geometry memory and live flags, indexed by id.
// ----------------------------------------------------------------------------
`default_nettype none

module rog_rect_table (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rog_pkg::t_tbl_req   i_req,
    output rog_pkg::t_geo            o_geo,
    output logic                     o_live
);

    rog_pkg::t_geo                     mem [rog_pkg::GEO_DEPTH];
    rog_pkg::t_geo                     r_geo;
    logic [rog_pkg::GEO_DEPTH-1:0]     r_live;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_geo;
        end
        if (i_req.rd_en) begin
            r_geo <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_req.live_set) begin
            r_live[i_req.live_addr] <= 1'b1;
        end else if (i_req.live_clr) begin
            r_live[i_req.live_addr] <= 1'b0;
        end
    end

    assign o_geo  = r_geo;
    assign o_live = r_live[i_req.live_addr];

endmodule

`default_nettype wire

// ===== rtl/core/rog_seq.sv =====
// ----------------------------------------------------------------------------
// rog_seq
// Operation sequencer: region walker for scans and fills, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rog_seq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [47:0]               i_s_tdata,
    input  wire logic [2:0]                i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [39:0]                    o_m_tdata,
    output logic [1:0]                     o_m_tuser,
    input  wire logic [6:0]                i_gw,
    input  wire logic [6:0]                i_gh,
    output rog_pkg::t_map_req              o_map_req,
    input  wire logic [rog_pkg::ID_W-1:0]  i_map_rdata,
    output rog_pkg::t_tbl_req              o_tbl_req,
    input  wire rog_pkg::t_geo             i_geo,
    input  wire logic                      i_live
);

    rog_pkg::t_state            r_state, n_state;
    logic [rog_pkg::CELL_AW-1:0] r_clr, n_clr;
    logic                       r_ovalid, n_ovalid;

    rog_pkg::t_func    r_func, n_func;
    logic [7:0]        r_id, n_id, r_fid, n_fid, r_fval, n_fval;
    logic [5:0]        r_px, n_px, r_py, n_py, r_step, n_step;
    logic [6:0]        r_ex, n_ex, r_ey, n_ey;
    rog_pkg::t_dir     r_dir, n_dir;
    logic [5:0]        r_gx, n_gx, r_gy, n_gy, r_nx, n_nx, r_ny, n_ny;
    logic [6:0]        r_gw, n_gw, r_gh, n_gh;
    rog_pkg::t_status  r_st, n_st;
    logic              r_sub, n_sub;
    logic [rog_pkg::RAD_W-1:0] r_rad, n_rad;
    logic [1:0]        r_side, n_side;
    rog_pkg::t_region  r_rg, n_rg;
    rog_pkg::t_coord   r_o, n_o, r_i, n_i;
    logic [39:0]       r_odata, n_odata;
    logic [1:0]        r_ouser, n_ouser;

    rog_pkg::t_region  reg_n;
    logic              load_reg, adv, scan_fin, scan_hit, fill_fin;
    logic              odone, iempty, in_grid, in_max;
    rog_pkg::t_coord   cx, cy, nxt_i, cols, rows;
    rog_pkg::t_coord   px, py, ex, ey, mgx, mgy, mgw, mgh, rgx, rgy, rgw, rgh;
    rog_pkg::t_coord   sx, sy;
    logic [6:0]        m_w, m_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rog_pkg::S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_id   <= n_id;   r_fid  <= n_fid;  r_fval <= n_fval;
        r_px   <= n_px;    r_py   <= n_py;   r_step <= n_step;
        r_ex   <= n_ex;    r_ey   <= n_ey;   r_dir  <= n_dir;
        r_gx   <= n_gx;    r_gy   <= n_gy;   r_gw   <= n_gw;   r_gh <= n_gh;
        r_nx   <= n_nx;    r_ny   <= n_ny;   r_st   <= n_st;   r_sub <= n_sub;
        r_rad  <= n_rad;   r_side <= n_side; r_rg   <= n_rg;
        r_o    <= n_o;     r_i    <= n_i;
        r_odata <= n_odata; r_ouser <= n_ouser;
    end

    assign cols = rog_pkg::t_coord'(i_gw);
    assign rows = rog_pkg::t_coord'(i_gh);
    assign px   = rog_pkg::t_coord'(r_px);
    assign py   = rog_pkg::t_coord'(r_py);
    assign ex   = rog_pkg::t_coord'(r_ex);
    assign ey   = rog_pkg::t_coord'(r_ey);
    assign m_w  = {1'b0, i_geo.wm1} + 7'd1;
    assign m_h  = {1'b0, i_geo.hm1} + 7'd1;
    assign mgx  = rog_pkg::t_coord'(i_geo.x);
    assign mgy  = rog_pkg::t_coord'(i_geo.y);
    assign mgw  = rog_pkg::t_coord'(m_w);
    assign mgh  = rog_pkg::t_coord'(m_h);
    assign rgx  = rog_pkg::t_coord'(r_gx);
    assign rgy  = rog_pkg::t_coord'(r_gy);
    assign rgw  = rog_pkg::t_coord'(r_gw);
    assign rgh  = rog_pkg::t_coord'(r_gh);

    assign cx      = r_rg.swap ? r_o : r_i;
    assign cy      = r_rg.swap ? r_i : r_o;
    assign nxt_i   = r_i + 1;
    assign odone   = r_rg.odn ? (r_o <= r_rg.oe) : (r_o >= r_rg.oe);
    assign iempty  = r_i >= r_rg.ie;
    assign in_grid = cx >= 0 && cy >= 0 && cx < cols && cy < rows;
    assign in_max  = cx >= 0 && cy >= 0 && cx < rog_pkg::t_coord'(rog_pkg::MAX_COLS)
                     && cy < rog_pkg::t_coord'(rog_pkg::MAX_ROWS);

    always_comb begin
        n_state = r_state;  n_clr = r_clr;    n_ovalid = r_ovalid;
        n_func  = r_func;   n_id  = r_id;     n_fid = r_fid;   n_fval = r_fval;
        n_px    = r_px;     n_py  = r_py;     n_step = r_step;
        n_ex    = r_ex;     n_ey  = r_ey;     n_dir = r_dir;
        n_gx    = r_gx;     n_gy  = r_gy;     n_gw = r_gw;     n_gh = r_gh;
        n_nx    = r_nx;     n_ny  = r_ny;     n_st = r_st;     n_sub = r_sub;
        n_rad   = r_rad;    n_side = r_side;  n_rg = r_rg;
        n_o     = r_o;      n_i   = r_i;
        n_odata = r_odata;  n_ouser = r_ouser;
        o_map_req = '0;
        o_tbl_req = '0;
        o_tbl_req.live_addr = r_id;
        reg_n    = r_rg;
        load_reg = 1'b0;
        adv      = 1'b0;
        scan_fin = 1'b0;
        scan_hit = 1'b0;
        fill_fin = 1'b0;
        sx = '0;
        sy = '0;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            rog_pkg::S_CLEAR: begin
                o_map_req.wr_en = 1'b1;
                o_map_req.addr  = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == rog_pkg::CELL_AW'(rog_pkg::CELLS - 1)) begin
                    n_state = rog_pkg::S_IDLE;
                end
            end
            rog_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func = rog_pkg::t_func'(i_s_tuser);
                    n_id   = i_s_tdata[7:0];
                    n_px   = i_s_tdata[13:8];
                    n_py   = i_s_tdata[19:14];
                    n_ex   = i_s_tdata[26:20];
                    n_ey   = i_s_tdata[33:27];
                    n_dir  = rog_pkg::t_dir'(i_s_tdata[35:34]);
                    n_step = i_s_tdata[41:36];
                    o_tbl_req.rd_en   = 1'b1;
                    o_tbl_req.rd_addr = i_s_tdata[7:0];
                    n_state = rog_pkg::S_GEO;
                end
            end
            rog_pkg::S_GEO: begin
                n_gx = i_geo.x;
                n_gy = i_geo.y;
                n_gw = m_w;
                n_gh = m_h;
                n_sub = 1'b0;
                n_state = rog_pkg::S_SCAN;
                load_reg = 1'b1;
                if (r_func == rog_pkg::FN_READ) begin
                    if (px < cols && py < rows) begin
                        reg_n = rog_pkg::raster(px, py, px + 1, py + 1);
                    end else begin
                        load_reg = 1'b0; n_st = rog_pkg::ST_OOB; n_state = rog_pkg::S_EMIT;
                    end
                end else if (r_func == rog_pkg::FN_AREA) begin
                    if (ex > cols || ey > rows) begin
                        load_reg = 1'b0; n_st = rog_pkg::ST_OOB; n_state = rog_pkg::S_EMIT;
                    end else begin
                        reg_n = rog_pkg::raster(px, py, ex, ey);
                    end
                end else if (r_id == '0) begin
                    load_reg = 1'b0; n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                end else if (r_func == rog_pkg::FN_PLACE) begin
                    if (i_live) begin
                        load_reg = 1'b0; n_st = rog_pkg::ST_BLOCKED;
                        n_state = rog_pkg::S_EMIT;
                    end else if (ex == 0 || ey == 0 || px + ex > cols || py + ey > rows) begin
                        load_reg = 1'b0; n_st = rog_pkg::ST_OOB; n_state = rog_pkg::S_EMIT;
                    end else begin
                        reg_n = rog_pkg::raster(px, py, px + ex, py + ey);
                    end
                end else if (!i_live) begin
                    load_reg = 1'b0; n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                end else begin
                    unique case (r_func)
                        rog_pkg::FN_TELEPORT: begin
                            n_nx = r_px;
                            n_ny = r_py;
                            if (px + mgw > cols || py + mgh > rows) begin
                                load_reg = 1'b0; n_st = rog_pkg::ST_OOB;
                                n_state = rog_pkg::S_EMIT;
                            end else begin
                                reg_n = rog_pkg::raster(px, py, px + mgw, py + mgh);
                            end
                        end
                        rog_pkg::FN_SLIDE: begin
                            sx = mgx;
                            sy = mgy;
                            unique case (r_dir)
                                rog_pkg::DIR_UP: begin
                                    sy = mgy - rog_pkg::t_coord'(r_step);
                                    reg_n = rog_pkg::raster(mgx, sy, mgx + mgw, mgy);
                                end
                                rog_pkg::DIR_DOWN: begin
                                    sy = mgy + rog_pkg::t_coord'(r_step);
                                    reg_n = rog_pkg::raster(mgx, mgy + mgh, mgx + mgw, sy + mgh);
                                end
                                rog_pkg::DIR_LEFT: begin
                                    sx = mgx - rog_pkg::t_coord'(r_step);
                                    reg_n = rog_pkg::raster(sx, mgy, mgx, mgy + mgh);
                                end
                                default: begin
                                    sx = mgx + rog_pkg::t_coord'(r_step);
                                    reg_n = rog_pkg::raster(mgx + mgw, mgy, sx + mgw, mgy + mgh);
                                end
                            endcase
                            n_nx = sx[5:0];
                            n_ny = sy[5:0];
                            if (r_step == '0) begin
                                load_reg = 1'b0; n_fid = r_id; n_st = rog_pkg::ST_OK;
                                n_state = rog_pkg::S_EMIT;
                            end else if (sx < 0 || sy < 0 || sx + mgw > cols
                                         || sy + mgh > rows) begin
                                load_reg = 1'b0; n_st = rog_pkg::ST_OOB;
                                n_state = rog_pkg::S_EMIT;
                            end
                        end
                        rog_pkg::FN_REMOVE: begin
                            n_fid  = r_id;
                            n_fval = '0;
                            reg_n  = rog_pkg::raster(mgx, mgy, mgx + mgw, mgy + mgh);
                            n_state = rog_pkg::S_FILL;
                        end
                        rog_pkg::FN_RAY: begin
                            reg_n = rog_pkg::ray_region(mgx, mgy, mgw, mgh, cols, rows, r_dir);
                        end
                        default: begin
                            n_rad  = rog_pkg::RAD_W'(1);
                            n_side = 2'd0;
                            reg_n  = rog_pkg::ring_region(mgx, mgy, mgw, mgh,
                                                          rog_pkg::t_coord'(1), 2'd0);
                        end
                    endcase
                end
            end
            rog_pkg::S_SCAN: begin
                if (odone || iempty) begin
                    scan_fin = 1'b1;
                end else if (in_grid) begin
                    o_map_req.rd_en = 1'b1;
                    o_map_req.addr  = {cy[rog_pkg::ROW_BITS-1:0], cx[rog_pkg::COL_BITS-1:0]};
                    n_state = rog_pkg::S_SCAN_W;
                end else begin
                    adv = 1'b1;
                end
            end
            rog_pkg::S_SCAN_W: begin
                n_state = rog_pkg::S_SCAN;
                if (i_map_rdata != '0) begin
                    scan_fin = 1'b1;
                    scan_hit = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            rog_pkg::S_FILL: begin
                if (odone || iempty) begin
                    fill_fin = 1'b1;
                end else begin
                    o_map_req.wr_en = in_max;
                    o_map_req.addr  = {cy[rog_pkg::ROW_BITS-1:0], cx[rog_pkg::COL_BITS-1:0]};
                    o_map_req.wdata = r_fval;
                    adv = 1'b1;
                end
            end
            rog_pkg::S_FETCH: begin
                o_tbl_req.rd_en   = 1'b1;
                o_tbl_req.rd_addr = r_fid;
                n_state = rog_pkg::S_FETCH_W;
            end
            rog_pkg::S_FETCH_W: begin
                n_gx = i_geo.x;
                n_gy = i_geo.y;
                n_gw = m_w;
                n_gh = m_h;
                n_st = rog_pkg::ST_OK;
                n_state = rog_pkg::S_EMIT;
            end
            rog_pkg::S_EMIT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_st;
                    n_odata  = (r_st == rog_pkg::ST_OK)
                             ? {6'd0, r_gh, r_gw, r_gy, r_gx, r_fid} : '0;
                    n_state  = rog_pkg::S_IDLE;
                end
            end
            default: n_state = rog_pkg::S_IDLE;
        endcase

        if (adv) begin
            if (nxt_i >= r_rg.ie) begin
                n_i = r_rg.is;
                n_o = r_rg.odn ? r_o - 1 : r_o + 1;
            end else begin
                n_i = nxt_i;
            end
        end

        if (scan_fin) begin
            priority case (r_func)
                rog_pkg::FN_READ, rog_pkg::FN_AREA, rog_pkg::FN_RAY: begin
                    if (scan_hit) begin
                        n_fid = i_map_rdata; n_state = rog_pkg::S_FETCH;
                    end else begin
                        n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                    end
                end
                rog_pkg::FN_RING: begin
                    if (scan_hit) begin
                        n_fid = i_map_rdata; n_state = rog_pkg::S_FETCH;
                    end else if (r_side != 2'd3) begin
                        n_side = r_side + 2'd1;
                        load_reg = 1'b1;
                        reg_n = rog_pkg::ring_region(rgx, rgy, rgw, rgh,
                                                     rog_pkg::t_coord'(r_rad), r_side + 2'd1);
                        n_state = rog_pkg::S_SCAN;
                    end else if (r_rad != rog_pkg::RAD_W'(rog_pkg::MAX_RADIUS - 1)) begin
                        n_rad  = r_rad + 1'b1;
                        n_side = 2'd0;
                        load_reg = 1'b1;
                        reg_n = rog_pkg::ring_region(rgx, rgy, rgw, rgh,
                                                     rog_pkg::t_coord'(r_rad + 1'b1), 2'd0);
                        n_state = rog_pkg::S_SCAN;
                    end else begin
                        n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                    end
                end
                rog_pkg::FN_PLACE: begin
                    if (scan_hit) begin
                        n_st = rog_pkg::ST_BLOCKED; n_state = rog_pkg::S_EMIT;
                    end else begin
                        o_tbl_req.wr_en   = 1'b1;
                        o_tbl_req.wr_addr = r_id;
                        o_tbl_req.wr_geo  = '{x: r_px, y: r_py,
                                              wm1: 6'(r_ex - 7'd1), hm1: 6'(r_ey - 7'd1)};
                        o_tbl_req.live_set = 1'b1;
                        n_fval = r_id;
                        load_reg = 1'b1;
                        reg_n = rog_pkg::raster(px, py, px + ex, py + ey);
                        n_state = rog_pkg::S_FILL;
                    end
                end
                rog_pkg::FN_TELEPORT, rog_pkg::FN_SLIDE: begin
                    if (scan_hit) begin
                        n_st = rog_pkg::ST_BLOCKED; n_state = rog_pkg::S_EMIT;
                    end else begin
                        n_fval = '0;
                        n_sub  = 1'b0;
                        load_reg = 1'b1;
                        reg_n = rog_pkg::raster(rgx, rgy, rgx + rgw, rgy + rgh);
                        n_state = rog_pkg::S_FILL;
                    end
                end
                default: begin
                    n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                end
            endcase
        end

        if (fill_fin) begin
            priority case (r_func)
                rog_pkg::FN_PLACE: begin
                    n_fid = r_id; n_state = rog_pkg::S_FETCH;
                end
                rog_pkg::FN_REMOVE: begin
                    o_tbl_req.live_clr = 1'b1;
                    n_st = rog_pkg::ST_OK;
                    n_state = rog_pkg::S_EMIT;
                end
                rog_pkg::FN_TELEPORT, rog_pkg::FN_SLIDE: begin
                    if (!r_sub) begin
                        o_tbl_req.wr_en   = 1'b1;
                        o_tbl_req.wr_addr = r_id;
                        o_tbl_req.wr_geo  = '{x: r_nx, y: r_ny,
                                              wm1: 6'(r_gw - 7'd1), hm1: 6'(r_gh - 7'd1)};
                        n_fval = r_id;
                        n_sub  = 1'b1;
                        load_reg = 1'b1;
                        reg_n = rog_pkg::raster(rog_pkg::t_coord'(r_nx), rog_pkg::t_coord'(r_ny),
                                                rog_pkg::t_coord'(r_nx) + rgw,
                                                rog_pkg::t_coord'(r_ny) + rgh);
                        n_state = rog_pkg::S_FILL;
                    end else begin
                        n_fid = r_id; n_state = rog_pkg::S_FETCH;
                    end
                end
                default: begin
                    n_st = rog_pkg::ST_NONE; n_state = rog_pkg::S_EMIT;
                end
            endcase
        end

        if (load_reg) begin
            n_rg = reg_n;
            n_o  = reg_n.os;
            n_i  = reg_n.is;
        end
    end

    assign o_s_tready = (r_state == rog_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

`default_nettype wire

// ===== rtl/core/rect_occupancy_grid.sv =====
// ----------------------------------------------------------------------------
// rect_occupancy_grid
// Grid map of rectangle ids with place, move, remove and search operations.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; a new one is taken as soon as the
// previous result is in the output register. Cost is set by the single port
// of the cell map: each in-grid cell read passes a request and a wait state,
// a skipped cell the request state alone, each cell written one fill step,
// and each scan or fill pass closes with an end check (a ring search makes
// one pass per ring side), plus table lookup and result handling. Checks
// that fail early skip to the result. After reset all 4096 map cells are
// cleared with no operation taken; grid size writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_occupancy_grid (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // block_id, pos_x, pos_y, extent_x, extent_y, direction, step_count, zero pad
    input  wire logic [47:0] i_s_tdata,
    // func
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // found_id, found_x, found_y, found_w, found_h, zero pad
    output logic [39:0]      o_m_tdata,
    // status
    output logic [1:0]       o_m_tuser
);

    localparam logic [6:0] COLS_MAX = 7'(rog_pkg::MAX_COLS);
    localparam logic [6:0] ROWS_MAX = 7'(rog_pkg::MAX_ROWS);

    logic [6:0]                r_gw, r_gh, cfg_clamp;
    rog_pkg::t_map_req         map_req;
    logic [rog_pkg::ID_W-1:0]  map_rdata;
    rog_pkg::t_tbl_req         tbl_req;
    rog_pkg::t_geo             tbl_geo;
    logic                      tbl_live;

    always_comb begin
        cfg_clamp = i_cfg_data;
        if (i_cfg_data == '0) begin
            cfg_clamp = 7'd1;
        end else if (i_cfg_index == 1'b0 && i_cfg_data > COLS_MAX) begin
            cfg_clamp = COLS_MAX;
        end else if (i_cfg_index == 1'b1 && i_cfg_data > ROWS_MAX) begin
            cfg_clamp = ROWS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= COLS_MAX;
            r_gh <= ROWS_MAX;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) begin
                r_gw <= cfg_clamp;
            end else begin
                r_gh <= cfg_clamp;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    rog_cell_map u_map (
        .i_clk   (i_clk),
        .i_req   (map_req),
        .o_rdata (map_rdata)
    );

    rog_rect_table u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_geo   (tbl_geo),
        .o_live  (tbl_live)
    );

    rog_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_gw        (r_gw),
        .i_gh        (r_gh),
        .o_map_req   (map_req),
        .i_map_rdata (map_rdata),
        .o_tbl_req   (tbl_req),
        .i_geo       (tbl_geo),
        .i_live      (tbl_live)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rog_checker.sv =====
// ----------------------------------------------------------------------------
// rog_checker
// Port-level checks for rect_occupancy_grid.
// ----------------------------------------------------------------------------
`default_nettype none

module rog_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != rog_pkg::ST_OK |-> o_m_tdata == '0)
        else $error("failed result carries data");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == rog_pkg::ST_OK |->
        o_m_tdata[7:0] != 8'd0 && o_m_tdata[26:20] != 7'd0 && o_m_tdata[33:27] != 7'd0)
        else $error("found result without id or size");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transfer taken while busy");

endmodule

bind rect_occupancy_grid rog_checker u_rog_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
